### design/pfp_pkg.sv
// Shared types and constants for the plane frame projection block.
`timescale 1ns / 1ps

package pfp_pkg;

    // Configuration register indexes
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic signed [31:0] third_x;
        logic signed [31:0] third_y;
        logic signed [31:0] third_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic               on_plane;
        logic [30:0]        plane_strength;
        logic               degenerate;
    } rsp_t;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_op_t;

    typedef struct packed {
        logic   start;
        rd_op_t op;
    } rd_req_t;

endpackage

### design/pfp_rootdiv.sv
// Bit-serial square root and divider, one result bit per cycle.
`timescale 1ns / 1ps

module pfp_rootdiv (
    input  logic             clk,
    input  logic             rst_n,
    input  pfp_pkg::rd_req_t ctrl,
    input  logic [63:0]      opa,
    input  logic [30:0]      divisor,
    output logic             done,
    output logic [31:0]      result
);
    import pfp_pkg::*;

    logic        busy_reg;
    rd_op_t      op_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [31:0] rem_reg;
    logic [31:0] nlo_reg;
    logic [31:0] q_reg;
    logic [30:0] div_reg;
    logic        done_reg;

    logic [63:0] bitv;
    logic [31:0] remsh;
    logic [63:0] sub_a;
    logic [63:0] sub_b;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        bitv  = 64'd1 << {~cnt_reg, 1'b0};
        remsh = {rem_reg[30:0], nlo_reg[31]};
        if (op_reg == RD_SQRT)
        begin
            sub_a = x_reg;
            sub_b = res_reg | bitv;
        end
        else
        begin
            sub_a = 64'(remsh);
            sub_b = 64'(div_reg);
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= RD_SQRT;
            cnt_reg  <= '0;
            x_reg    <= '0;
            res_reg  <= '0;
            rem_reg  <= '0;
            nlo_reg  <= '0;
            q_reg    <= '0;
            div_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                cnt_reg  <= '0;
                x_reg    <= opa;
                res_reg  <= '0;
                rem_reg  <= 32'(opa[60:32]);
                nlo_reg  <= opa[31:0];
                q_reg    <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (op_reg == RD_SQRT)
                begin
                    if (ge)
                    begin
                        x_reg   <= diff[63:0];
                        res_reg <= (res_reg >> 1) | bitv;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                end
                else
                begin
                    rem_reg <= ge ? diff[31:0] : remsh;
                    nlo_reg <= {nlo_reg[30:0], 1'b0};
                    q_reg   <= {q_reg[30:0], ge};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == RD_SQRT) ? res_reg[31:0] : q_reg;

endmodule

### design/plane_frame_projection.sv
// Top level of the plane frame projection block: sequencer and shared multiplier.
`timescale 1ns / 1ps

// A kind 0 item sets up a plane frame from three points and returns the cross
// magnitude and a degenerate flag; a kind 1 item projects one point into the
// stored frame. One item is worked on at a time and req_stall stays high until
// its result is in the output register. A kind 1 item goes through a load,
// nine passes through the shared multiplier, three rounding steps and a finish.
// The time of a kind 0 item is set by the 32-step root/divide unit, run
// thirteen times when none of the three vectors to normalise is zero (one root
// and three divides for each of three unit vectors, plus the strength root), by
// the one-bit-a-cycle normalising shifter (up to 29 steps a vector) and by the
// cross products on the shared multiplier. A zero vector skips its root and
// divides. A stalled output register adds its stall.
module plane_frame_projection #(
    parameter int COORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pfp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pfp_pkg::rsp_t rsp,
    input  logic          cfg_write,
    input  logic          cfg_index,
    input  logic [30:0]   cfg_data
);
    import pfp_pkg::*;

    localparam int CwEff = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int ExtSh = 32 - CwEff;
    localparam logic signed [37:0] SatHi = 38'((64'd1 << (CwEff - 1)) - 64'd1);
    localparam logic signed [37:0] SatLo = -SatHi - 38'sd1;
    localparam logic signed [67:0] HalfQ30 = 68'sd1 <<< 29;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD_D1,
        ST_LOAD_D2,
        ST_UN_ABS,
        ST_UN_NORM,
        ST_UN_SQ,
        ST_UN_ROOT_GO,
        ST_UN_ROOT_WAIT,
        ST_UN_DIV_GO,
        ST_UN_DIV_WAIT,
        ST_UN_DONE,
        ST_CR_A,
        ST_CR_B,
        ST_CR_R,
        ST_STR_SQ,
        ST_STR_ROOT_GO,
        ST_STR_ROOT_WAIT,
        ST_LOAD_N,
        ST_FIN0,
        ST_LOAD_P,
        ST_DOT,
        ST_DOT_R,
        ST_FIN1
    } state_t;

    typedef enum logic [1:0] {
        SEL_U,
        SEL_W,
        SEL_NN
    } unit_sel_t;

    function automatic logic signed [31:0] sext(input logic [31:0] f);
        logic [31:0] t;
        t = f << ExtSh;
        sext = $signed(t) >>> ExtSh;
    endfunction

    function automatic logic [1:0] nxt(input logic [1:0] c);
        case (c)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd2;
            default: nxt = 2'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [37:0] x);
        if (x > SatHi)
            sat = 32'(SatHi);
        else if (x < SatLo)
            sat = 32'(SatLo);
        else
            sat = 32'(x);
    endfunction

    state_t             state_reg;
    unit_sel_t          usel_reg;
    logic               xsel_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         idx_reg;
    req_t               item_reg;
    logic [30:0]        tol_reg;
    logic [30:0]        thr_reg;
    logic signed [33:0] vec_reg [3];
    logic [32:0]        mag_reg [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] org_reg [3];
    logic signed [31:0] nrm_reg [3];
    logic signed [31:0] uax_reg [3];
    logic signed [31:0] vax_reg [3];
    logic signed [67:0] acc_reg;
    logic [30:0]        len_reg;
    logic [30:0]        str_reg;
    logic signed [37:0] dist_reg;
    logic signed [31:0] cu_reg;
    logic signed [31:0] cv_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic signed [31:0] p0 [3];
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic [32:0]        mx;
    logic [1:0]         i1;
    logic [1:0]         i2;
    logic signed [31:0] opa [3];
    logic signed [31:0] opb [3];
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod;
    logic signed [67:0] acc_sum;
    logic [67:0]        absacc;
    logic [67:0]        rsum;
    logic [37:0]        rq;
    logic signed [31:0] crv;
    logic signed [67:0] rnd;
    logic signed [37:0] dotv;
    logic [37:0]        distmag;
    rd_req_t            rd_ctrl;
    logic [63:0]        rd_opa;
    logic               rd_done;
    logic [31:0]        rd_result;
    logic [31:0]        qv;
    logic signed [31:0] qs;

    always_comb
    begin
        p0[0] = sext(item_reg.first_x);
        p0[1] = sext(item_reg.first_y);
        p0[2] = sext(item_reg.first_z);
        p1[0] = sext(item_reg.second_x);
        p1[1] = sext(item_reg.second_y);
        p1[2] = sext(item_reg.second_z);
        p2[0] = sext(item_reg.third_x);
        p2[1] = sext(item_reg.third_y);
        p2[2] = sext(item_reg.third_z);
    end

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
            mx = mag_reg[1];
        if (mag_reg[2] > mx)
            mx = mag_reg[2];
    end

    // Cross operands: u x w for the normal, nn x u for the v axis
    always_comb
    begin
        i1 = nxt(idx_reg);
        i2 = nxt(i1);
        for (int i = 0; i < 3; i++)
        begin
            opa[i] = xsel_reg ? nrm_reg[i] : uax_reg[i];
            opb[i] = xsel_reg ? uax_reg[i] : w_reg[i];
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_UN_SQ:
            begin
                mul_a = 34'(mag_reg[idx_reg]);
                mul_b = 32'(mag_reg[idx_reg]);
            end
            ST_STR_SQ:
            begin
                mul_a = 34'(n_reg[idx_reg]);
                mul_b = n_reg[idx_reg];
            end
            ST_CR_A:
            begin
                mul_a = 34'(opa[i1]);
                mul_b = opb[i2];
            end
            ST_CR_B:
            begin
                mul_a = 34'(opa[i2]);
                mul_b = opb[i1];
            end
            ST_DOT:
            begin
                mul_a = vec_reg[idx_reg];
                case (axis_reg)
                    2'd0:    mul_b = nrm_reg[idx_reg];
                    2'd1:    mul_b = uax_reg[idx_reg];
                    default: mul_b = vax_reg[idx_reg];
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod    = mul_a * mul_b;
        acc_sum = ((idx_reg == 2'd0) ? 68'sd0 : acc_reg) + 68'(prod);
    end

    // Round Q8.60 to Q2.30 half away from zero, clamp to one
    always_comb
    begin
        absacc = acc_reg[67] ? 68'(-acc_reg) : 68'(acc_reg);
        rsum   = absacc + 68'(HalfQ30);
        rq     = rsum[67:30];
        if (rq > 38'(ONE_Q30))
            rq = 38'(ONE_Q30);
        crv = acc_reg[67] ? -32'(rq) : 32'(rq);
    end

    always_comb
    begin
        rnd     = acc_reg + HalfQ30;
        dotv    = rnd[67:30];
        distmag = dist_reg[37] ? 38'(-dist_reg) : 38'(dist_reg);
    end

    always_comb
    begin
        rd_ctrl.start = (state_reg == ST_UN_ROOT_GO) || (state_reg == ST_UN_DIV_GO)
                        || (state_reg == ST_STR_ROOT_GO);
        rd_ctrl.op    = (state_reg == ST_UN_DIV_GO) ? RD_DIV : RD_SQRT;
        if (state_reg == ST_UN_DIV_GO)
            rd_opa = 64'({mag_reg[idx_reg][29:0], 30'd0}) + 64'(len_reg >> 1);
        else
            rd_opa = acc_reg[63:0];
        qv = rd_result;
        qs = vec_reg[idx_reg][33] ? -qv : qv;
    end

    pfp_rootdiv u_rootdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rd_ctrl),
        .opa     (rd_opa),
        .divisor (len_reg),
        .done    (rd_done),
        .result  (rd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            usel_reg      <= SEL_U;
            xsel_reg      <= 1'b0;
            axis_reg      <= '0;
            idx_reg       <= '0;
            item_reg      <= '0;
            tol_reg       <= '0;
            thr_reg       <= '0;
            acc_reg       <= '0;
            len_reg       <= '0;
            str_reg       <= '0;
            dist_reg      <= '0;
            cu_reg        <= '0;
            cv_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i] <= '0;
                mag_reg[i] <= '0;
                w_reg[i]   <= '0;
                n_reg[i]   <= '0;
                org_reg[i] <= '0;
                nrm_reg[i] <= '0;
                uax_reg[i] <= '0;
                vax_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_TOLERANCE)
                    tol_reg <= cfg_data;
                else
                    thr_reg <= cfg_data;
            end

            // The finishing states reload the output register themselves
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_FIN0
                && state_reg != ST_FIN1)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg  <= req;
                        state_reg <= req.kind ? ST_LOAD_P : ST_LOAD_D1;
                    end
                end
                ST_LOAD_D1:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= 34'(p1[i]) - 34'(p0[i]);
                    usel_reg  <= SEL_U;
                    state_reg <= ST_UN_ABS;
                end
                ST_LOAD_D2:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= 34'(p2[i]) - 34'(p0[i]);
                    usel_reg  <= SEL_W;
                    state_reg <= ST_UN_ABS;
                end
                ST_LOAD_N:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= 34'(n_reg[i]);
                    usel_reg  <= SEL_NN;
                    state_reg <= ST_UN_ABS;
                end
                ST_UN_ABS:
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= vec_reg[i][33] ? 33'(-vec_reg[i]) : 33'(vec_reg[i]);
                    state_reg <= ST_UN_NORM;
                end
                ST_UN_NORM:
                begin
                    // Bring the largest magnitude into [2^29, 2^30)
                    if (mx == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            case (usel_reg)
                                SEL_U:   uax_reg[i] <= '0;
                                SEL_W:   w_reg[i]   <= '0;
                                default: nrm_reg[i] <= '0;
                            endcase
                        end
                        state_reg <= ST_UN_DONE;
                    end
                    else if (mx[32:30] != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!mx[29])
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] << 1;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_UN_SQ;
                    end
                end
                ST_UN_SQ:
                begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_UN_ROOT_GO;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ST_UN_ROOT_GO:
                    state_reg <= ST_UN_ROOT_WAIT;
                ST_UN_ROOT_WAIT:
                begin
                    if (rd_done)
                    begin
                        len_reg   <= rd_result[30:0];
                        state_reg <= ST_UN_DIV_GO;
                    end
                end
                ST_UN_DIV_GO:
                    state_reg <= ST_UN_DIV_WAIT;
                ST_UN_DIV_WAIT:
                begin
                    if (rd_done)
                    begin
                        case (usel_reg)
                            SEL_U:   uax_reg[idx_reg] <= qs;
                            SEL_W:   w_reg[idx_reg]   <= qs;
                            default: nrm_reg[idx_reg] <= qs;
                        endcase
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_UN_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_UN_DIV_GO;
                        end
                    end
                end
                ST_UN_DONE:
                begin
                    idx_reg <= '0;
                    case (usel_reg)
                        SEL_U:   state_reg <= ST_LOAD_D2;
                        SEL_W:
                        begin
                            xsel_reg  <= 1'b0;
                            state_reg <= ST_CR_A;
                        end
                        default:
                        begin
                            xsel_reg  <= 1'b1;
                            state_reg <= ST_CR_A;
                        end
                    endcase
                end
                ST_CR_A:
                begin
                    acc_reg   <= 68'(prod);
                    state_reg <= ST_CR_B;
                end
                ST_CR_B:
                begin
                    acc_reg   <= acc_reg - 68'(prod);
                    state_reg <= ST_CR_R;
                end
                ST_CR_R:
                begin
                    if (xsel_reg)
                        vax_reg[idx_reg] <= crv;
                    else
                        n_reg[idx_reg] <= crv;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= xsel_reg ? ST_FIN0 : ST_STR_SQ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_CR_A;
                    end
                end
                ST_STR_SQ:
                begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_STR_ROOT_GO;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ST_STR_ROOT_GO:
                    state_reg <= ST_STR_ROOT_WAIT;
                ST_STR_ROOT_WAIT:
                begin
                    if (rd_done)
                    begin
                        if (rd_result > 32'(ONE_Q30))
                            str_reg <= ONE_Q30;
                        else
                            str_reg <= rd_result[30:0];
                        state_reg <= ST_LOAD_N;
                    end
                end
                ST_FIN0:
                begin
                    // Hold until the output register is free
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        for (int i = 0; i < 3; i++)
                            org_reg[i] <= p0[i];
                        rsp_reg.coord_u        <= '0;
                        rsp_reg.coord_v        <= '0;
                        rsp_reg.on_plane       <= 1'b0;
                        rsp_reg.plane_strength <= str_reg;
                        rsp_reg.degenerate     <= (str_reg <= thr_reg);
                        rsp_valid_reg          <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                ST_LOAD_P:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= 34'(p0[i]) - 34'(org_reg[i]);
                    idx_reg   <= '0;
                    axis_reg  <= '0;
                    state_reg <= ST_DOT;
                end
                ST_DOT:
                begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DOT_R;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ST_DOT_R:
                begin
                    case (axis_reg)
                        2'd0:    dist_reg <= dotv;
                        2'd1:    cu_reg   <= sat(dotv);
                        default: cv_reg   <= sat(dotv);
                    endcase
                    if (axis_reg == 2'd2)
                        state_reg <= ST_FIN1;
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_DOT;
                    end
                end
                ST_FIN1:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.coord_u        <= cu_reg;
                        rsp_reg.coord_v        <= cv_reg;
                        rsp_reg.on_plane       <= (distmag <= 38'(tol_reg));
                        rsp_reg.plane_strength <= '0;
                        rsp_reg.degenerate     <= 1'b0;
                        rsp_valid_reg          <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for the plane frame projection block.
`timescale 1ns / 1ps

module testbench;

    import pfp_pkg::*;

    typedef longint vec3_t [3];

    localparam int WATCHDOG_LIMIT = 6000;
    localparam longint Q30 = 64'sd1 << 30;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_write;
    logic        cfg_index;
    logic [30:0] cfg_data;

    // Predicted frame and register copies
    longint      tol_reg;
    longint      thr_reg;
    vec3_t       org_st;
    vec3_t       nrm_st;
    vec3_t       uax_st;
    vec3_t       vax_st;

    rsp_t        pending_rsp[$];
    int          mismatches;
    int          planes_sent;
    int          points_sent;
    int          rsp_seen;
    int          idle_cycles;
    int          stall_left;
    bit          quiet_rx;
    bit          quiet_tx;
    bit          req_taken;
    bit          rsp_taken;

    // Last plane points, used to aim projections on or near the plane
    logic signed [31:0] last_pt[9];

    plane_frame_projection #(
        .COORD_WIDTH(32)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic vec3_t unit_vec(vec3_t v);
        longint unsigned m[3];
        longint unsigned mx = 0;
        longint unsigned sum = 0;
        longint unsigned len;
        longint unsigned q;
        vec3_t o;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return o;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic longint round_q60(longint d);
        longint unsigned r;
        r = (mag(d) + (64'd1 << 29)) >> 30;
        if (r > Q30)
            r = Q30;
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = round_q60(a[1] * b[2] - a[2] * b[1]);
        o[1] = round_q60(a[2] * b[0] - a[0] * b[2]);
        o[2] = round_q60(a[0] * b[1] - a[1] * b[0]);
        return o;
    endfunction

    function automatic longint dot_q16(vec3_t d, vec3_t ax);
        longint hi = 0;
        longint lo = 0;
        longint p;
        longint low;
        for (int i = 0; i < 3; i++)
        begin
            p = d[i] * ax[i];
            low = p & (Q30 - 1);
            hi += (p - low) >>> 30;
            lo += low;
        end
        return hi + ((lo + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > 64'sd2147483647)
            x = 64'sd2147483647;
        if (x < -64'sd2147483648)
            x = -64'sd2147483648;
        return x[31:0];
    endfunction

    // Work out the result of one item and, for a plane item, advance the frame copy
    function automatic rsp_t predict_frame(req_t r);
        rsp_t  o;
        vec3_t p0;
        vec3_t d1;
        vec3_t d2;
        vec3_t u;
        vec3_t w;
        vec3_t n;
        vec3_t nn;
        vec3_t d;
        longint unsigned sum = 0;
        longint unsigned strength;
        o = '0;
        p0[0] = r.first_x; p0[1] = r.first_y; p0[2] = r.first_z;
        if (r.kind == 1'b0)
        begin
            d1[0] = longint'(r.second_x) - p0[0];
            d1[1] = longint'(r.second_y) - p0[1];
            d1[2] = longint'(r.second_z) - p0[2];
            d2[0] = longint'(r.third_x) - p0[0];
            d2[1] = longint'(r.third_y) - p0[1];
            d2[2] = longint'(r.third_z) - p0[2];
            u = unit_vec(d1);
            w = unit_vec(d2);
            n = cross3(u, w);
            for (int i = 0; i < 3; i++)
                sum += n[i] * n[i];
            strength = int_sqrt(sum);
            if (strength > Q30)
                strength = Q30;
            nn = unit_vec(n);
            org_st = p0;
            nrm_st = nn;
            uax_st = u;
            vax_st = cross3(nn, u);
            o.plane_strength = strength[30:0];
            o.degenerate = (strength <= thr_reg);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                d[i] = p0[i] - org_st[i];
            o.coord_u = sat32(dot_q16(d, uax_st));
            o.coord_v = sat32(dot_q16(d, vax_st));
            o.on_plane = (mag(dot_q16(d, nrm_st)) <= tol_reg);
        end
        return o;
    endfunction

    function automatic int pick_gap();
        int c;
        c = $urandom_range(0, 99);
        if (c < 60)
            return 0;
        if (c < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int c;
        c = $urandom_range(0, 99);
        if (c < 30)
            return $urandom;
        if (c < 60)
            return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        if (c < 70)
        begin
            case ($urandom_range(0, 2))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                default: return 32'h0;
            endcase
        end
        return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    endfunction

    task automatic send_item(req_t r);
        @(negedge clk);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp = {pending_rsp, predict_frame(r)};
        if (r.kind == 1'b0)
        begin
            planes_sent++;
            last_pt = '{r.first_x, r.first_y, r.first_z, r.second_x, r.second_y,
                        r.second_z, r.third_x, r.third_y, r.third_z};
        end
        else
            points_sent++;
    endtask

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    task automatic send_with_gap(req_t r);
        send_item(r);
        if (!quiet_tx)
            hold_off(pick_gap());
    endtask

    function automatic req_t make_plane(logic signed [31:0] a[9]);
        req_t r;
        r.kind = 1'b0;
        r.first_x = a[0]; r.first_y = a[1]; r.first_z = a[2];
        r.second_x = a[3]; r.second_y = a[4]; r.second_z = a[5];
        r.third_x = a[6]; r.third_y = a[7]; r.third_z = a[8];
        return r;
    endfunction

    function automatic req_t make_point(logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z);
        req_t r;
        r = '0;
        r.kind = 1'b1;
        r.first_x = x; r.first_y = y; r.first_z = z;
        // Unused fields carry noise
        r.second_x = $urandom; r.second_y = $urandom; r.second_z = $urandom;
        r.third_x = $urandom; r.third_y = $urandom; r.third_z = $urandom;
        return r;
    endfunction

    task automatic wait_drained();
        hold_off(1);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        wait_drained();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_TOLERANCE)
            tol_reg = val;
        else
            thr_reg = val;
    endtask

    task automatic test_unset_frame();
        send_with_gap(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
        send_with_gap(make_point(32'h0, 32'h0, 32'h0));
    endtask

    task automatic test_directed_planes();
        // Axis-aligned plane z = 0
        send_with_gap(make_plane('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}));
        send_with_gap(make_point(32'h30000, 32'h50000, 0));
        send_with_gap(make_point(32'h30000, 32'h50000, 32'h1));
        send_with_gap(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_with_gap(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // Coincident points: both vectors zero
        send_with_gap(make_plane('{5, 6, 7, 5, 6, 7, 5, 6, 7}));
        send_with_gap(make_point(32'h100, 32'h200, 32'h300));
        // Collinear points
        send_with_gap(make_plane('{0, 0, 0, 32'h10000, 32'h10000, 0,
                                   32'h20000, 32'h20000, 0}));
        // Extreme corners, including the widest differences
        send_with_gap(make_plane('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}));
        send_with_gap(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_with_gap(make_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        send_with_gap(make_plane('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                   32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff}));
        send_with_gap(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // Second point coincident with the origin, third not
        send_with_gap(make_plane('{1, 2, 3, 1, 2, 3, 32'h40000, 2, 3}));
        send_with_gap(make_point(32'h40000, 2, 3));
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_TOLERANCE, 31'h7fff_ffff);
        write_reg(CFG_THRESHOLD, 31'h7fff_ffff);
        send_with_gap(make_plane('{0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000}));
        send_with_gap(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        write_reg(CFG_THRESHOLD, 31'h4000_0000);
        send_with_gap(make_plane('{0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000}));
        write_reg(CFG_THRESHOLD, 31'h3fff_ffff);
        send_with_gap(make_plane('{0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000}));
        write_reg(CFG_TOLERANCE, 31'd0);
        send_with_gap(make_point(32'h5, 32'h7, 32'h0));
    endtask

    task automatic send_random_sequence();
        logic signed [31:0] a[9];
        int c;
        int k;
        c = $urandom_range(0, 99);
        if (c < 85)
        begin
            for (int i = 0; i < 9; i++)
                a[i] = rand_coord();
            k = $urandom_range(0, 9);
            if (k == 0)
                for (int i = 3; i < 6; i++)
                    a[i] = a[i - 3];
            else if (k == 1)
                for (int i = 6; i < 9; i++)
                    a[i] = a[i - 3] + (a[i - 3] - a[i - 6]);
            else if (k == 2)
                for (int i = 6; i < 9; i++)
                    a[i] = a[i - 3] + $signed($urandom_range(0, 8)) - 4;
            send_with_gap(make_plane(a));
            repeat ($urandom_range(2, 8))
            begin
                k = $urandom_range(0, 3);
                if (k == 0)
                    send_with_gap(make_point(rand_coord(), rand_coord(), rand_coord()));
                else
                begin
                    // Near a point of the plane
                    int j;
                    j = 3 * $urandom_range(0, 2);
                    send_with_gap(make_point(
                        last_pt[j] + $signed($urandom_range(0, 64)) - 32,
                        last_pt[j + 1] + $signed($urandom_range(0, 64)) - 32,
                        last_pt[j + 2] + $signed($urandom_range(0, 64)) - 32));
                end
            end
        end
        else
        begin
            // Noise: a single item of either kind with raw content
            req_t r;
            r = $urandom;
            r.kind = $urandom_range(0, 1);
            r.first_x = $urandom; r.first_y = $urandom; r.first_z = $urandom;
            r.second_x = $urandom; r.second_y = $urandom; r.second_z = $urandom;
            r.third_x = $urandom; r.third_y = $urandom; r.third_z = $urandom;
            send_with_gap(r);
        end
    endtask

    task automatic test_random_phases();
        int target;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_TOLERANCE, 31'd0); write_reg(CFG_THRESHOLD, 31'd0); end
                1: begin write_reg(CFG_TOLERANCE, 31'h7fff_ffff);
                         write_reg(CFG_THRESHOLD, 31'h4000_0000); end
                2: begin write_reg(CFG_TOLERANCE, 31'd256);
                         write_reg(CFG_THRESHOLD, 31'h7fff_ffff); end
                default:
                begin
                    write_reg(CFG_TOLERANCE,
                              31'($urandom_range(0, 1 << 12) << $urandom_range(0, 18)));
                    write_reg(CFG_THRESHOLD, 31'($urandom_range(0, 32'h4000_0000)));
                end
            endcase
            quiet_rx = (ph == 4);
            quiet_tx = (ph == 5);
            target = planes_sent + points_sent + 228;
            while (planes_sent + points_sent < target)
                send_random_sequence();
        end
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        repeat (4)
            send_random_sequence();
        wait_drained();
        repeat (4)
            send_random_sequence();
    endtask

    // Receiver: check each accepted result, then choose the next stall
    initial
    begin
        rsp_t want;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_taken = rsp_valid && !rsp_stall && rst_n;
            if (rsp_taken)
            begin
                rsp_seen++;
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", rsp);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.coord_u !== want.coord_u || rsp.coord_v !== want.coord_v ||
                        rsp.on_plane !== want.on_plane ||
                        rsp.plane_strength !== want.plane_strength ||
                        rsp.degenerate !== want.degenerate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp u=%h v=%h on=%b str=%h deg=%b, got u=%h v=%h on=%b str=%h deg=%b",
                                     want.coord_u, want.coord_v, want.on_plane,
                                     want.plane_strength, want.degenerate, rsp.coord_u,
                                     rsp.coord_v, rsp.on_plane, rsp.plane_strength,
                                     rsp.degenerate);
                    end
                end
            end
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_rx && $urandom_range(0, 7) == 0)
            begin
                stall_left = pick_gap();
                rsp_stall <= (stall_left > 0);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no item moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            req_taken = req_valid && !req_stall && rst_n;
            #1;
            if (req_taken || rsp_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", pending_rsp.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_TOLERANCE;
        cfg_data = '0;
        tol_reg = 0;
        thr_reg = 0;
        for (int i = 0; i < 3; i++)
        begin
            org_st[i] = 0; nrm_st[i] = 0; uax_st[i] = 0; vax_st[i] = 0;
        end
        for (int i = 0; i < 9; i++)
            last_pt[i] = 0;
        mismatches = 0;
        planes_sent = 0;
        points_sent = 0;
        rsp_seen = 0;
        stall_left = 0;
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unset_frame();
        test_directed_planes();
        test_register_extremes();
        test_pause_until_drained();
        test_random_phases();

        wait_drained();
        repeat (50) @(posedge clk);
        $display("covered %0d plane set-ups and %0d projections, %0d results checked",
                 planes_sent, points_sent, rsp_seen);
        $display("register settings swept from zero to full scale; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### plane_frame_projection.f
design/pfp_pkg.sv
design/pfp_rootdiv.sv
design/plane_frame_projection.sv
test/testbench.sv
